// File: sv/fha_pkg.sv
// Shared types and codes for the first-fit heap allocator.
// Used by the cell, the top level and the checker; depends on nothing.
package fha_pkg;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FULL      = 2'd1,
    ST_FREED     = 2'd2,
    ST_BAD       = 2'd3
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ALLOC,
    S_FREE,
    S_MPREV,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STEP,
    CMD_ALLOC,
    CMD_FREE,
    CMD_MPREV
  } cmd_e;

  localparam int unsigned FW = 11;  // width of the request and offset fields

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    cmd_e          op;     // what the cells do this cycle
    op_e           kind;   // request kind, selects the match rule
    logic          shift;  // split (allocate) or merge with next (free)
    logic [FW-1:0] req;
    logic [FW-1:0] addr;
  } cell_cmd_t;

endpackage

// File: sv/fha_cell.sv
// One block table entry of the first-fit heap allocator: size, free mark and
// the scan token with its running header offset. Depends on fha_pkg.
module fha_cell
  import fha_pkg::*;
#(
  parameter int unsigned SW         = 11,
  parameter int unsigned HW         = 12,
  parameter int unsigned H          = 24,
  parameter bit          FIRST      = 1'b0,
  parameter int unsigned RESET_SIZE = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cell_cmd_t     cmd_i,
  input  logic [SW-1:0] prev_size_i,
  input  logic          prev_free_i,
  input  logic          prev_tok_i,
  input  logic [HW-1:0] prev_hdr_i,
  input  logic [SW-1:0] next_size_i,
  input  logic          next_free_i,
  input  logic          next_tok_i,
  output logic [SW-1:0] size_o,
  output logic          free_o,
  output logic          tok_o,
  output logic [HW-1:0] hdr_o,
  output logic [HW-1:0] hdr_next_o,
  output logic          hit_o,
  output logic          hit_nf_o,
  output logic          hit_pf_o
);

  localparam int unsigned CW = HW + FW + 1;

  logic [SW-1:0] size_q, size_d;
  logic          free_q, free_d;
  logic          tok_q, tok_d;
  logic          passed_q, passed_d;
  logic [HW-1:0] hdr_q, hdr_d;
  logic          fits, at_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= SW'(RESET_SIZE);
      free_q   <= FIRST;
      tok_q    <= 1'b0;
      passed_q <= 1'b0;
      hdr_q    <= '0;
    end else begin
      size_q   <= size_d;
      free_q   <= free_d;
      tok_q    <= tok_d;
      passed_q <= passed_d;
      hdr_q    <= hdr_d;
    end
  end

  assign fits    = free_q && (CW'(size_q) >= CW'(cmd_i.req));
  assign at_addr = (CW'(hdr_q) + CW'(H)) == CW'(cmd_i.addr);

  always_comb begin
    size_d   = size_q;
    free_d   = free_q;
    tok_d    = tok_q;
    passed_d = passed_q;
    hdr_d    = hdr_q;
    unique case (cmd_i.op)
      CMD_START: begin
        tok_d    = FIRST;
        hdr_d    = '0;
        passed_d = 1'b0;
      end
      CMD_STEP: begin
        tok_d    = prev_tok_i;
        hdr_d    = prev_hdr_i;
        passed_d = passed_q | tok_q;
      end
      CMD_ALLOC: begin
        if (tok_q) begin
          free_d = 1'b0;
          if (cmd_i.shift) size_d = SW'(cmd_i.req);
        end else if (!passed_q && cmd_i.shift) begin
          // open a gap after the split block, new free remainder goes in it
          if (prev_tok_i) begin
            size_d = SW'(CW'(prev_size_i) - CW'(cmd_i.req) - CW'(H));
            free_d = 1'b1;
          end else begin
            size_d = prev_size_i;
            free_d = prev_free_i;
          end
        end
      end
      CMD_FREE: begin
        if (tok_q) begin
          free_d = 1'b1;
          if (cmd_i.shift) size_d = SW'(CW'(size_q) + CW'(next_size_i) + CW'(H));
        end else if (!passed_q && cmd_i.shift) begin
          size_d = next_size_i;
          free_d = next_free_i;
        end
      end
      CMD_MPREV: begin
        if (next_tok_i) begin
          size_d = SW'(CW'(size_q) + CW'(next_size_i) + CW'(H));
        end else if (!passed_q) begin
          size_d = next_size_i;
          free_d = next_free_i;
        end
      end
      default: ;
    endcase
  end

  assign size_o     = size_q;
  assign free_o     = free_q;
  assign tok_o      = tok_q;
  assign hdr_o      = hdr_q;
  assign hdr_next_o = HW'(CW'(hdr_q) + CW'(H) + CW'(size_q));
  assign hit_o      = tok_q && ((cmd_i.kind == OP_ALLOC) ? fits : at_addr);
  assign hit_nf_o   = tok_q && next_free_i;
  assign hit_pf_o   = tok_q && prev_free_i;

endmodule

// File: sv/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: request sequencer, result
// register and the row of fha_cell table entries. Depends on fha_pkg, fha_cell.
//
// Usage
//   Requests enter on the s_axis group. tuser carries the operation
//   (0 allocate, 1 free); tdata carries request_size in bits [10:0] and
//   free_address in bits [21:11]. Results leave on the m_axis group: tuser is
//   the status, tdata holds data_offset in [10:0] and reported_size in [21:11].
//   Blocks live in a row of cells in address order. A scan token walks down
//   the row one cell per cycle and carries the running header offset with it;
//   the first cell that matches stops it. A split opens a gap by moving every
//   later cell one place up together, a merge closes one by moving them down.
//   The time from acceptance to result is set by the walk of the token, one
//   entry per cycle, up to the hit or, on a miss, over every block in use.
//   One request is in flight at a time; s_axis_tready_o is high only when
//   idle.
//   Reset leaves one free block spanning the arena less one header.
//   When the receiver stalls, hold the result in the output register; the
//   next request is still taken and worked through, and its result waits
//   until the held one is handed over.
module first_fit_heap_allocator
  import fha_pkg::*;
#(
  parameter int unsigned ARENA_BYTES  = 2048,
  parameter int unsigned HEADER_BYTES = 24,
  parameter int unsigned MAX_BLOCKS   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // request_size[10:0], free_address[21:11]
  input  logic        s_axis_tuser_i,   // operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // data_offset[10:0], reported_size[21:11]
  output logic [1:0]  m_axis_tuser_o    // status
);

  localparam int unsigned SW   = $clog2(ARENA_BYTES);
  localparam int unsigned HW   = SW + 1;
  localparam int unsigned CW   = HW + FW + 1;
  localparam int unsigned CNTW = $clog2(MAX_BLOCKS + 1);

  state_e          state_q, state_d;
  logic [CNTW-1:0] idx_q, idx_d, cnt_q, cnt_d;
  op_e             op_q, op_d;
  logic [FW-1:0]   req_q, req_d, addr_q, addr_d;
  status_e         status_q, status_d;
  logic [FW-1:0]   off_q, off_d, rsz_q, rsz_d;
  logic [SW-1:0]   hsize_q, hsize_d;
  logic            mv_q, mv_d;
  status_e         mstat_q, mstat_d;
  logic [FW-1:0]   moff_q, moff_d, msz_q, msz_d;
  cell_cmd_t       cmd;
  logic            split;

  logic [SW-1:0] size_w [MAX_BLOCKS];
  logic [HW-1:0] hdr_w  [MAX_BLOCKS];
  logic [HW-1:0] hnxt_w [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] free_w, tok_w, hit_w, hnf_w, hpf_w;
  logic [SW-1:0] hit_size;
  logic [HW-1:0] hit_hdr;

  // row of table entries
  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    logic [SW-1:0] p_size, n_size;
    logic          p_free, p_tok, n_free, n_tok;
    logic [HW-1:0] p_hdr;
    if (k == 0) begin : g_first
      assign p_size = '0;
      assign p_free = 1'b0;
      assign p_tok  = 1'b0;
      assign p_hdr  = '0;
    end else begin : g_mid
      assign p_size = size_w[k-1];
      assign p_free = free_w[k-1];
      assign p_tok  = tok_w[k-1];
      assign p_hdr  = hnxt_w[k-1];
    end
    if (k == MAX_BLOCKS - 1) begin : g_last
      assign n_size = '0;
      assign n_free = 1'b0;
      assign n_tok  = 1'b0;
    end else begin : g_inner
      assign n_size = size_w[k+1];
      assign n_free = free_w[k+1];
      assign n_tok  = tok_w[k+1];
    end
    fha_cell #(
      .SW(SW), .HW(HW), .H(HEADER_BYTES), .FIRST(k == 0),
      .RESET_SIZE((k == 0) ? (ARENA_BYTES - HEADER_BYTES) : 0)
    ) u_cell (
      .clk_i, .rst_ni, .cmd_i(cmd),
      .prev_size_i(p_size), .prev_free_i(p_free), .prev_tok_i(p_tok),
      .prev_hdr_i(p_hdr),
      .next_size_i(n_size), .next_free_i(n_free), .next_tok_i(n_tok),
      .size_o(size_w[k]), .free_o(free_w[k]), .tok_o(tok_w[k]),
      .hdr_o(hdr_w[k]), .hdr_next_o(hnxt_w[k]),
      .hit_o(hit_w[k]), .hit_nf_o(hnf_w[k]), .hit_pf_o(hpf_w[k])
    );
  end

  // token is one-hot, so pick the holder's fields by and-or
  always_comb begin
    hit_size = '0;
    hit_hdr  = '0;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      hit_size |= size_w[k] & {SW{tok_w[k]}};
      hit_hdr  |= hdr_w[k] & {HW{tok_w[k]}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      cnt_q   <= CNTW'(1);
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    req_q    <= req_d;
    addr_q   <= addr_d;
    status_q <= status_d;
    off_q    <= off_d;
    rsz_q    <= rsz_d;
    hsize_q  <= hsize_d;
    mstat_q  <= mstat_d;
    moff_q   <= moff_d;
    msz_q    <= msz_d;
  end

  assign split = ((CW'(hsize_q) - CW'(req_q)) > CW'(HEADER_BYTES))
                 && (cnt_q < CNTW'(MAX_BLOCKS));

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    op_d     = op_q;
    req_d    = req_q;
    addr_d   = addr_q;
    status_d = status_q;
    off_d    = off_q;
    rsz_d    = rsz_q;
    hsize_d  = hsize_q;
    mv_d     = mv_q;
    mstat_d  = mstat_q;
    moff_d   = moff_q;
    msz_d    = msz_q;
    cmd.op    = CMD_NONE;
    cmd.kind  = op_q;
    cmd.shift = 1'b0;
    cmd.req   = req_q;
    cmd.addr  = addr_q;
    s_axis_tready_o = (state_q == S_IDLE);

    // result register: drop it once taken
    if (mv_q && m_axis_tready_i) mv_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d    = op_e'(s_axis_tuser_i);
          req_d   = s_axis_tdata_i[10:0];
          addr_d  = s_axis_tdata_i[21:11];
          idx_d   = '0;
          cmd.op  = CMD_START;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_q == cnt_q) begin
          status_d = (op_q == OP_ALLOC) ? ST_FULL : ST_BAD;
          off_d    = '0;
          rsz_d    = '0;
          state_d  = S_DONE;
        end else if (|hit_w) begin
          off_d   = FW'(CW'(hit_hdr) + CW'(HEADER_BYTES));
          hsize_d = hit_size;
          if (op_q == OP_ALLOC) begin
            status_d = ST_ALLOCATED;
            rsz_d    = req_q;
            state_d  = S_ALLOC;
          end else begin
            status_d = ST_FREED;
            off_d    = '0;
            rsz_d    = FW'(hit_size);
            state_d  = S_FREE;
          end
        end else begin
          cmd.op = CMD_STEP;
          idx_d  = idx_q + CNTW'(1);
        end
      end
      S_ALLOC: begin
        cmd.op    = CMD_ALLOC;
        cmd.shift = split;
        if (split) cnt_d = cnt_q + CNTW'(1);
        state_d = S_DONE;
      end
      S_FREE: begin
        cmd.op    = CMD_FREE;
        cmd.shift = |hnf_w;
        if (|hnf_w) cnt_d = cnt_q - CNTW'(1);
        state_d = S_MPREV;
      end
      S_MPREV: begin
        if (|hpf_w) begin
          cmd.op = CMD_MPREV;
          cnt_d  = cnt_q - CNTW'(1);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!mv_q || m_axis_tready_i) begin
          mv_d    = 1'b1;
          mstat_d = status_q;
          moff_d  = off_q;
          msz_d   = rsz_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tuser_o  = mstat_q;
  assign m_axis_tdata_o  = {2'b00, msz_q, moff_q};

endmodule

// File: sv/fha_checker.sv
// Port-level checks for the first-fit heap allocator, bound to the top level.
// Depends on fha_pkg and first_fit_heap_allocator.
module fha_checker
  import fha_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = 24
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  // one request in flight: input closes right after a request is taken
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second request taken while busy");

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_FULL || m_axis_tuser_o == ST_BAD)
      |-> m_axis_tdata_o == 24'd0)
    else $error("failed request carries data");

  a_freed_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ST_FREED |-> m_axis_tdata_o[10:0] == 11'd0)
    else $error("free reports an offset");

  a_alloc_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ST_ALLOCATED
      |-> m_axis_tdata_o[10:0] != 11'd0 || (HEADER_BYTES % 2048) == 0)
    else $error("allocation offset inside first header");

endmodule

bind first_fit_heap_allocator fha_checker #(.HEADER_BYTES(HEADER_BYTES)) u_fha_checker (.*);
